// ===== rtl/core/lwsf_pkg.sv =====
// Shared constants, types and character classification for the long word stream filter.
// No dependencies; imported by lwsf_word_track and long_word_stream_filter_core.
`default_nettype none

package lwsf_pkg;

    localparam int WORD_CAPACITY = 63;
    localparam int CHAR_W        = 8;
    localparam int CFG_W         = 6;
    localparam int LEN_W         = 7;
    localparam int LEN_SAT       = (1 << LEN_W) - 1;
    localparam int ADDR_W        = (WORD_CAPACITY > 1) ? $clog2(WORD_CAPACITY) : 1;
    localparam int CNT_W         = $clog2(WORD_CAPACITY + 1);

    localparam logic [CFG_W-1:0] MAX_LETTERS_RESET = CFG_W'(63);

    typedef struct packed {
        logic             in_word;
        logic             too_long;
        logic             has_symbol;
        logic             overflowed;
        logic [LEN_W-1:0] length;
    } word_status_t;

    // Space . , newline NUL ? ! ; : - _ ( ) tab / & and double quote.
    function automatic logic is_delim(input logic [CHAR_W-1:0] c);
        return c inside {8'h20, 8'h2E, 8'h2C, 8'h0A, 8'h00, 8'h3F, 8'h21, 8'h3B,
                         8'h3A, 8'h2D, 8'h5F, 8'h28, 8'h29, 8'h09, 8'h2F, 8'h26,
                         8'h22};
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lwsf_word_track.sv =====
// Word buffer and per-word flags: the word store memory, length counter and status bits.
// Depends on lwsf_pkg.
`default_nettype none

module lwsf_word_track
    import lwsf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              char_wr,
    input  wire logic              word_clear,
    input  wire logic [CHAR_W-1:0] char_in,
    input  wire logic [CFG_W-1:0]  max_letters,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [CHAR_W-1:0]      rd_data,
    output word_status_t           status
);

    logic [CHAR_W-1:0] word_mem [WORD_CAPACITY];
    logic [CHAR_W-1:0] rd_data_reg;

    logic             in_word_reg, in_word_next;
    logic             too_long_reg, too_long_next;
    logic             has_symbol_reg, has_symbol_next;
    logic             overflowed_reg, overflowed_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic [LEN_W-1:0] base_len;
    logic             base_ovf;
    logic             store_ok;

    assign base_len = in_word_reg ? len_reg : '0;
    assign base_ovf = in_word_reg ? overflowed_reg : 1'b0;
    assign store_ok = base_len < LEN_W'(WORD_CAPACITY);

    always_comb begin
        in_word_next    = in_word_reg;
        too_long_next   = too_long_reg;
        has_symbol_next = has_symbol_reg;
        overflowed_next = overflowed_reg;
        len_next        = len_reg;
        if (word_clear) begin
            in_word_next    = 1'b0;
            too_long_next   = 1'b0;
            has_symbol_next = 1'b0;
            overflowed_next = 1'b0;
            len_next        = '0;
        end else if (char_wr) begin
            has_symbol_next = has_symbol_reg | ~is_letter(char_in);
            overflowed_next = base_ovf | ~store_ok;
            len_next        = (base_len < LEN_W'(LEN_SAT)) ? base_len + 1'b1 : base_len;
            too_long_next   = too_long_reg | (len_next > {1'b0, max_letters});
            in_word_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_word_reg    <= 1'b0;
            too_long_reg   <= 1'b0;
            has_symbol_reg <= 1'b0;
            overflowed_reg <= 1'b0;
            len_reg        <= '0;
        end else begin
            in_word_reg    <= in_word_next;
            too_long_reg   <= too_long_next;
            has_symbol_reg <= has_symbol_next;
            overflowed_reg <= overflowed_next;
            len_reg        <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (char_wr && !word_clear && store_ok) begin
            word_mem[base_len[ADDR_W-1:0]] <= char_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= word_mem[rd_addr];
        end
    end

    assign rd_data           = rd_data_reg;
    assign status.in_word    = in_word_reg;
    assign status.too_long   = too_long_reg;
    assign status.has_symbol = has_symbol_reg;
    assign status.overflowed = overflowed_reg;
    assign status.length     = len_reg;

`ifndef NO_ASSERTIONS
    a_idle_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_word_reg |-> len_reg == '0)
        else $error("word length nonzero outside a word");

    a_idle_flags_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_word_reg |-> !too_long_reg && !has_symbol_reg && !overflowed_reg)
        else $error("word flags set outside a word");

    a_clear_ends_word: assert property (@(posedge aclk) disable iff (!aresetn)
        word_clear |=> !in_word_reg && len_reg == '0)
        else $error("delimiter did not close the word");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/long_word_stream_filter_core.sv =====
// Top level of the long word stream filter: input handshake, emit sequencer, output register.
// Depends on lwsf_pkg and lwsf_word_track.
`default_nettype none

// The filter takes one character byte per input word and gives back the filtered stream.
// Bytes that are not delimiters are collected into the current word; each one is
// accepted while the sequencer is idle and produces no output. A delimiter (space, period, comma, newline, NUL,
// question mark, exclamation mark, semicolon, colon, hyphen, underscore, both parentheses,
// tab, slash, ampersand, double quote) closes the word: the stored bytes are sent one per
// output word, unless the word holds only letters and is longer than max_letters, and then
// the delimiter itself is sent with m_last high. m_word_overflow is high on every output
// word of a run whose word went past the 63-byte store; extra bytes are dropped. The store
// has one read port, so the sequencer reads a byte into registered read data in ST_READ
// and hands it to the output register in ST_PUSH. The sequencer waits while m_ready holds
// the output register full, and s_ready stays low from the closing delimiter until that
// delimiter has been loaded into the output register. The output register lets a new
// input word be taken while the closing delimiter still waits downstream. max_letters
// resets to 63 and is written through cfg_we and cfg_wdata; the user must write it only
// while the filter is idle, which the block itself does not enforce.

module long_word_stream_filter_core
    import lwsf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CHAR_W-1:0] s_in_char,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CHAR_W-1:0]      m_out_char,
    output logic                   m_last,
    output logic                   m_word_overflow,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_PUSH  = 4'b0100,
        ST_DELIM = 4'b1000
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CHAR_W-1:0] delim_reg, delim_next;
    logic              ovf_reg, ovf_next;
    logic [CFG_W-1:0]  max_letters_reg;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    word_status_t      status;
    logic [CHAR_W-1:0] rd_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic              in_take;
    logic              in_delim;
    logic              char_wr;
    logic              word_clear;
    logic              out_free;
    logic              snap_emit;
    logic              snap_ovf;
    logic [CNT_W-1:0]  snap_cnt;
    logic [CNT_W-1:0]  idx_inc;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_take    = s_valid && s_ready;
    assign in_delim   = is_delim(s_in_char);
    assign char_wr    = in_take && !in_delim;
    assign word_clear = in_take && in_delim;
    assign out_free   = !out_valid_reg || m_ready;

    // What the closing delimiter sees of the word that it ends.
    assign snap_ovf  = status.in_word && status.overflowed;
    assign snap_emit = status.in_word && (status.has_symbol || !status.too_long);
    assign snap_cnt  = (status.length > LEN_W'(WORD_CAPACITY)) ? CNT_W'(WORD_CAPACITY)
                                                               : status.length[CNT_W-1:0];
    assign idx_inc   = CNT_W'(idx_reg) + 1'b1;

    lwsf_word_track u_word_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .char_wr     (char_wr),
        .word_clear  (word_clear),
        .char_in     (s_in_char),
        .max_letters (max_letters_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .status      (status)
    );

    // Sequencer: a delimiter snapshots the word, then the stored bytes of a kept, non-empty word
    // are read one at a time and pushed into the output register, and the delimiter goes out last.
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        delim_next     = delim_reg;
        ovf_next       = ovf_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        case (state_reg)
            ST_IDLE: begin
                if (word_clear) begin
                    delim_next = s_in_char;
                    ovf_next   = snap_ovf;
                    cnt_next   = snap_cnt;
                    idx_next   = '0;
                    state_next = (snap_emit && snap_cnt != '0) ? ST_READ : ST_DELIM;
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data;
                    out_last_next  = 1'b0;
                    out_ovf_next   = ovf_reg;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = (idx_inc == cnt_reg) ? ST_DELIM : ST_READ;
                end
            end
            ST_DELIM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = delim_reg;
                    out_last_next  = 1'b1;
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            max_letters_reg <= MAX_LETTERS_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                max_letters_reg <= cfg_wdata;
            end
        end
    end

    // Payload and sequencer bookkeeping need no reset.
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        delim_reg    <= delim_next;
        ovf_reg      <= ovf_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_out_char      = out_char_reg;
    assign m_last          = out_last_reg;
    assign m_word_overflow = out_ovf_reg;

`ifndef NO_ASSERTIONS
    a_push_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH || state_reg == ST_READ) |-> CNT_W'(idx_reg) < cnt_reg)
        else $error("read index ran past the kept word length");

    a_suppressed_to_delim: assert property (@(posedge aclk) disable iff (!aresetn)
        (word_clear && !snap_emit) |=> state_reg == ST_DELIM)
        else $error("suppressed word did not go straight to the delimiter");

    a_delim_sets_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DELIM && out_free) |=> m_valid && m_last && m_out_char == delim_reg)
        else $error("closing delimiter not presented with last");

    a_push_clears_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH && out_free) |=> m_valid && !m_last)
        else $error("word byte presented with last");
`endif

endmodule

`default_nettype wire
